// ===== rtl/core/mlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpf_pkg: shared types and codes of the multilevel priority FIFO
// Operation and status codes, fixed port widths and the control structs
// passed between the top level, the level cells and the entry pool.
// ----------------------------------------------------------------------------
package mlpf_pkg;

    localparam int OP_W   = 2;
    localparam int PRIO_W = 3;
    localparam int ITEM_W = 32;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Update strobes broadcast to every level cell.
    typedef struct packed {
        logic enq;
        logic deq;
    } lvl_cmd_t;

    // Access strobes for the entry pool.
    typedef struct packed {
        logic rd_en;
        logic value_we;
        logic link_we;
        logic alloc;
    } pool_ctl_t;

endpackage

// ===== rtl/core/mlpf_level_cell.sv =====
// ----------------------------------------------------------------------------
// mlpf_level_cell: list ends of one priority level
// Holds head, tail and the non-empty flag of one level and takes part in
// the priority chain that marks the highest non-empty level.
// ----------------------------------------------------------------------------
module mlpf_level_cell
    import mlpf_pkg::*;
#(
    parameter int IDX = 0,
    parameter int LW  = 3,
    parameter int AW  = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lvl_cmd_t      cmd,
    input  logic [LW-1:0] cmd_level,
    input  logic [AW-1:0] entry,
    input  logic [AW-1:0] next_head,
    input  logic          higher_found,
    output logic          found_out,
    output logic          is_top,
    output logic          nonempty,
    output logic [AW-1:0] head,
    output logic [AW-1:0] tail
);

    logic          nonempty_reg;
    logic          nonempty_next;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic          hit;

    assign hit = (cmd_level == LW'(IDX));

    always_comb
    begin
        nonempty_next = nonempty_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        if (cmd.enq && hit)
        begin
            // append: an empty level also takes the entry as its head
            if (!nonempty_reg)
            begin
                head_next     = entry;
                nonempty_next = 1'b1;
            end
            tail_next = entry;
        end
        else if (cmd.deq && hit)
        begin
            // drop the head; the last entry empties the level
            if (head_reg == tail_reg)
            begin
                nonempty_next = 1'b0;
            end
            else
            begin
                head_next = next_head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= 1'b0;
        end
        else
        begin
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign found_out = higher_found | nonempty_reg;
    assign is_top    = nonempty_reg & ~higher_found;
    assign nonempty  = nonempty_reg;
    assign head      = head_reg;
    assign tail      = tail_reg;

endmodule

// ===== rtl/core/mlpf_pool.sv =====
// ----------------------------------------------------------------------------
// mlpf_pool: shared entry pool
// Value and link memories with registered reads. A fill mark stands in for
// the reset free chain: an entry at or above it reads its link as the next
// entry in order.
// ----------------------------------------------------------------------------
module mlpf_pool
    import mlpf_pkg::*;
#(
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pool_ctl_t                            ctl,
    input  logic [$clog2(POOL_DEPTH)-1:0]        rd_addr,
    input  logic [$clog2(POOL_DEPTH)-1:0]        value_wr_addr,
    input  logic [VALUE_WIDTH-1:0]               value_wr_data,
    input  logic [$clog2(POOL_DEPTH)-1:0]        link_wr_addr,
    input  logic [$clog2(POOL_DEPTH)-1:0]        link_wr_data,
    output logic [VALUE_WIDTH-1:0]               rd_value,
    output logic [$clog2(POOL_DEPTH)-1:0]        rd_link
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] value_mem [POOL_DEPTH];
    logic [AW-1:0]          link_mem  [POOL_DEPTH];

    logic [VALUE_WIDTH-1:0] value_rd_reg;
    logic [AW-1:0]          link_rd_reg;
    logic [AW-1:0]          addr_rd_reg;
    logic                   fresh_rd_reg;
    logic [CW-1:0]          fill_reg;
    logic [CW-1:0]          fill_next;
    logic [AW-1:0]          succ;

    always_ff @(posedge clk)
    begin
        if (ctl.value_we)
        begin
            value_mem[value_wr_addr] <= value_wr_data;
        end
        if (ctl.link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
        if (ctl.rd_en)
        begin
            value_rd_reg <= value_mem[rd_addr];
            link_rd_reg  <= link_mem[rd_addr];
            addr_rd_reg  <= rd_addr;
            fresh_rd_reg <= (CW'(rd_addr) >= fill_reg);
        end
    end

    // advance the mark when a never-used entry is handed out
    assign fill_next = (ctl.alloc && fresh_rd_reg) ? fill_reg + CW'(1) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign succ     = (addr_rd_reg == AW'(POOL_DEPTH - 1)) ? '0 : addr_rd_reg + AW'(1);
    assign rd_link  = fresh_rd_reg ? succ : link_rd_reg;
    assign rd_value = value_rd_reg;

endmodule

// ===== rtl/core/multilevel_priority_fifo.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_fifo: strict priority FIFO over a shared entry pool
// One linked list per priority level in a pool of POOL_DEPTH entries.
// Enqueue appends to the tail of a level; dequeue removes and peek reads
// the head of the highest non-empty level. One result per item.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid, in_ready  | opcode, prio_level, item_value
//  out     | out_valid, out_ready| out_value, out_level, status
//
//  Steps: ST_IDLE accepts, finds the top level in the cell chain and starts
//  the registered read of the pool memories; ST_EXEC, which takes no new
//  item, writes link, value and list pointers and loads the result register.
//  Stalls: ST_EXEC holds while the result register is full and
//  not taken; a new item is accepted while an earlier result still waits.
//  Reset: takes effect at once, no clearing pass; the pool fill mark
//  replaces the reset free chain.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo
    import mlpf_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          opcode,
    input  logic [PRIO_W-1:0]        prio_level,
    input  logic signed [ITEM_W-1:0] item_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ITEM_W-1:0] out_value,
    output logic [PRIO_W-1:0]        out_level,
    output logic [STAT_W-1:0]        status
);

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    // level count seen by the 3-bit reduction; zero when no reduction needed
    localparam logic [PRIO_W-1:0] NL_RED = PRIO_W'(NUM_LEVELS < 8 ? NUM_LEVELS : 0);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // item captured at accept
    logic [OP_W-1:0]        op_reg;
    logic [LW-1:0]          lvl_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   top_found_reg;
    logic [LW-1:0]          top_idx_reg;
    logic [AW-1:0]          addr_reg;

    // queue state
    logic [AW-1:0]          free_head_reg;
    logic [AW-1:0]          free_head_next;
    logic [CW-1:0]          used_reg;
    logic [CW-1:0]          used_next;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [ITEM_W-1:0] out_value_reg;
    logic signed [ITEM_W-1:0] out_value_next;
    logic [PRIO_W-1:0]        out_level_reg;
    logic [PRIO_W-1:0]        out_level_next;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;

    // cell chain
    logic [NUM_LEVELS:0]    chain;
    logic [NUM_LEVELS-1:0]  cell_top;
    logic [NUM_LEVELS-1:0]  cell_nonempty;
    logic [AW-1:0]          cell_head [NUM_LEVELS];
    logic [AW-1:0]          cell_tail [NUM_LEVELS];
    lvl_cmd_t               cell_cmd;
    logic [LW-1:0]          cell_level;

    // pool
    pool_ctl_t              pool_ctl;
    logic [AW-1:0]          pool_rd_addr;
    logic [AW-1:0]          link_wr_addr;
    logic [AW-1:0]          link_wr_data;
    logic [VALUE_WIDTH-1:0] pool_value;
    logic [AW-1:0]          pool_link;

    // decode and control
    logic                   accept;
    logic                   fire;
    logic                   is_enq;
    logic                   is_deq;
    logic                   full;
    logic                   alloc;
    logic                   release_entry;
    logic [PRIO_W-1:0]      prio_red;
    logic [LW-1:0]          lvl_in;
    logic                   top_found;
    logic [LW-1:0]          top_idx;
    logic [AW-1:0]          top_head;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // Reduce an out-of-range level modulo NUM_LEVELS; three steps cover
    // every 3-bit level for any count of two or more.
    always_comb
    begin
        prio_red = prio_level;
        for (int k = 0; k < 3; k++)
        begin
            if (NL_RED != '0 && prio_red >= NL_RED)
            begin
                prio_red = prio_red - NL_RED;
            end
        end
    end
    assign lvl_in = LW'(prio_red);

    // Priority chain: the highest level starts with nothing found above it.
    assign chain[NUM_LEVELS] = 1'b0;
    assign top_found         = chain[0];

    for (genvar i = 0; i < NUM_LEVELS; i++)
    begin : g_cell
        mlpf_level_cell #(
            .IDX (i),
            .LW  (LW),
            .AW  (AW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cell_cmd),
            .cmd_level    (cell_level),
            .entry        (addr_reg),
            .next_head    (pool_link),
            .higher_found (chain[i+1]),
            .found_out    (chain[i]),
            .is_top       (cell_top[i]),
            .nonempty     (cell_nonempty[i]),
            .head         (cell_head[i]),
            .tail         (cell_tail[i])
        );
    end

    // One-hot top mark to level index and head pointer.
    always_comb
    begin
        top_idx  = '0;
        top_head = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (cell_top[i])
            begin
                top_idx  = top_idx | LW'(i);
                top_head = top_head | cell_head[i];
            end
        end
    end

    // Enqueue reads the free head entry; dequeue and peek read the top head.
    assign pool_rd_addr = (opcode == OP_ENQ) ? free_head_reg : top_head;

    always_comb
    begin
        is_enq = 1'b0;
        is_deq = 1'b0;
        case (op_reg)
            OP_ENQ:  is_enq = 1'b1;
            OP_DEQ:  is_deq = 1'b1;
            OP_PEEK: is_deq = 1'b0;
            default: is_deq = 1'b0;   // unused code behaves as peek
        endcase
    end

    assign full          = (used_reg == CW'(POOL_DEPTH));
    assign alloc         = fire & is_enq & ~full;
    assign release_entry = fire & is_deq & top_found_reg;

    // Level cell updates land when the item fires in ST_EXEC.
    assign cell_cmd.enq = alloc;
    assign cell_cmd.deq = release_entry;
    assign cell_level   = alloc ? lvl_reg : top_idx_reg;

    // Link the new entry behind the current tail, or push a freed entry
    // onto the free list.
    assign link_wr_addr = alloc ? cell_tail[lvl_reg] : addr_reg;
    assign link_wr_data = alloc ? addr_reg : free_head_reg;

    assign pool_ctl.rd_en    = accept;
    assign pool_ctl.value_we = alloc;
    assign pool_ctl.link_we  = (alloc & cell_nonempty[lvl_reg]) | release_entry;
    assign pool_ctl.alloc    = alloc;

    mlpf_pool #(
        .POOL_DEPTH  (POOL_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_pool (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (pool_ctl),
        .rd_addr       (pool_rd_addr),
        .value_wr_addr (addr_reg),
        .value_wr_data (val_reg),
        .link_wr_addr  (link_wr_addr),
        .link_wr_data  (link_wr_data),
        .rd_value      (pool_value),
        .rd_link       (pool_link)
    );

    always_comb
    begin
        free_head_next = free_head_reg;
        used_next      = used_reg;
        if (alloc)
        begin
            free_head_next = pool_link;
            used_next      = used_reg + CW'(1);
        end
        else if (release_entry)
        begin
            free_head_next = addr_reg;
            used_next      = used_reg - CW'(1);
        end
    end

    // State and result register.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_value_next = out_value_reg;
        out_level_next = out_level_reg;
        status_next    = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_level_next = '0;
                    status_next    = STAT_OK;
                    if (is_enq)
                    begin
                        out_level_next = PRIO_W'(lvl_reg);
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    else if (top_found_reg)
                    begin
                        out_value_next = $signed(ITEM_W'(pool_value));
                        out_level_next = PRIO_W'(top_idx_reg);
                    end
                    else
                    begin
                        status_next = STAT_EMPTY;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_level_reg <= '0;
            status_reg    <= STAT_OK;
            free_head_reg <= '0;
            used_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_level_reg <= out_level_next;
            status_reg    <= status_next;
            free_head_reg <= free_head_next;
            used_reg      <= used_next;
        end
    end

    // Payload: capture at accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= opcode;
            lvl_reg       <= lvl_in;
            val_reg       <= VALUE_WIDTH'($unsigned(item_value));
            top_found_reg <= top_found;
            top_idx_reg   <= top_idx;
            addr_reg      <= pool_rd_addr;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_level = out_level_reg;
    assign status    = status_reg;

    // Pool accounting never overruns the pool.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(POOL_DEPTH))
        else $error("used count beyond pool depth");

    // An empty pool means no level may be marked non-empty.
    a_empty_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0) |-> !top_found)
        else $error("level non-empty while pool is empty");

    // At most one cell claims the top level.
    a_top_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_top))
        else $error("more than one top level");

    // A completed dequeue returns exactly one entry to the free list.
    a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
        release_entry |=> used_reg == $past(used_reg) - CW'(1))
        else $error("dequeue did not release one entry");

endmodule
